// File: rtl/icl_pkg.sv
package icl_pkg;

  // fixed field widths
  localparam int unsigned INDEX_WIDTH      = 9;
  localparam int unsigned LOAD_INDEX_WIDTH = 8;
  localparam int unsigned TOL_WIDTH        = 32;
  localparam int unsigned CFG_INDEX_WIDTH  = 1;
  localparam int unsigned CFG_DATA_WIDTH   = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_COUNT = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_TOL   = 1'd1;

  // reset values of the registers
  localparam logic [INDEX_WIDTH-1:0] CELL_COUNT_RESET = 9'd1;
  localparam logic [TOL_WIDTH-1:0]   EDGE_TOL_RESET   = 32'd1;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVAL,
    ST_DONE
  } icl_state_t;

  // outcome of comparing the value against one edge
  typedef struct packed {
    logic near;   // within tolerance of the edge
    logic below;  // strictly below the edge
  } icl_cmp_t;

endpackage

// File: rtl/icl_if.sv
interface icl_in_if #(
  parameter int COORD_WIDTH = 48
);
  logic                                     valid;
  logic                                     ready;
  logic                                     kind;
  logic [icl_pkg::LOAD_INDEX_WIDTH-1:0]     load_index;
  logic signed [COORD_WIDTH-1:0]            lower_edge;
  logic signed [COORD_WIDTH-1:0]            upper_edge;
  logic signed [COORD_WIDTH-1:0]            value;
  logic                                     bias_right;
  logic [icl_pkg::INDEX_WIDTH-1:0]          start_hint;

  modport source (
    output valid, kind, load_index, lower_edge, upper_edge, value, bias_right, start_hint,
    input  ready
  );
  modport sink (
    input  valid, kind, load_index, lower_edge, upper_edge, value, bias_right, start_hint,
    output ready
  );
endinterface

interface icl_out_if;
  logic                            valid;
  logic                            ready;
  logic [icl_pkg::INDEX_WIDTH-1:0] cell_index;
  logic                            found;

  modport source (
    output valid, cell_index, found,
    input  ready
  );
  modport sink (
    input  valid, cell_index, found,
    output ready
  );
endinterface

// File: rtl/icl_ram.sv
module icl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/icl_edge_cmp.sv
module icl_edge_cmp #(
  parameter int COORD_WIDTH = 48
) (
  input  logic signed [COORD_WIDTH-1:0]      value,
  input  logic signed [COORD_WIDTH-1:0]      edge_pos,
  input  logic [icl_pkg::TOL_WIDTH-1:0]      tolerance,
  output icl_pkg::icl_cmp_t                  result
);

  localparam int CMP_WIDTH = (COORD_WIDTH + 1 > icl_pkg::TOL_WIDTH) ?
                             COORD_WIDTH + 1 : icl_pkg::TOL_WIDTH;

  logic signed [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH:0]        abs_diff;

  // exact difference, one bit wider so it cannot overflow
  assign diff = {value[COORD_WIDTH-1], value} - {edge_pos[COORD_WIDTH-1], edge_pos};
  assign abs_diff = diff[COORD_WIDTH] ? -diff : diff;

  assign result.below = diff[COORD_WIDTH];
  assign result.near  = CMP_WIDTH'(abs_diff) <= CMP_WIDTH'(tolerance);

endmodule

// File: rtl/interval_cell_locator_core.sv
// channel  | dir | payload                                              | transfer
// ---------+-----+------------------------------------------------------+------------------
// in_ch    | in  | kind load_index lower_edge upper_edge value           | valid && ready
//          |     | bias_right start_hint                                |
// out_ch   | out | cell_index found                                     | valid && ready
// cfg      | in  | cfg_index cfg_data                                   | cfg_we
//
// A load writes the cell table directly while the block is idle.
// A query examines one cell at a time, since the table has a single read port:
// a table read (LOOK), then a compare (EVAL). DONE hands the result to the output
// register once it is free. The search begins at the hint cell, may restart at cell 0.
// rst is synchronous; the table itself is not cleared.
// A waiting result sits in the output register while the next item is taken.
module interval_cell_locator_core #(
  parameter int CELL_DEPTH  = 256,
  parameter int COORD_WIDTH = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  icl_in_if.sink                                 in_ch,
  icl_out_if.source                              out_ch,
  input  logic                                   cfg_we,
  input  logic [icl_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [icl_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  localparam int AW = $clog2(CELL_DEPTH);
  localparam int IW = icl_pkg::INDEX_WIDTH;

  icl_pkg::icl_state_t state, state_next;

  logic [IW-1:0]                   cell_count;
  logic [icl_pkg::TOL_WIDTH-1:0]   edge_tolerance;
  logic [IW-1:0]                   eff_count;

  logic [IW-1:0]                   pos, pos_next;
  logic                            hint_phase, hint_phase_next;
  logic signed [COORD_WIDTH-1:0]   x_val;
  logic                            bias;
  logic [IW-1:0]                   res_index, res_index_next;
  logic                            res_found, res_found_next;

  logic                            out_valid;
  logic [IW-1:0]                   out_index;
  logic                            out_found;
  logic                            out_load;

  logic                            in_xfer;
  logic                            mem_we;
  logic [AW-1:0]                   mem_raddr;
  logic [2*COORD_WIDTH-1:0]        mem_rdata;
  logic signed [COORD_WIDTH-1:0]   rd_lower;
  logic signed [COORD_WIDTH-1:0]   rd_upper;
  logic                            pos_past_end;

  icl_pkg::icl_cmp_t               cmp_lower;
  icl_pkg::icl_cmp_t               cmp_upper;
  logic                            eval_finish;
  logic                            eval_found;
  logic                            eval_restart;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count     <= icl_pkg::CELL_COUNT_RESET;
      edge_tolerance <= icl_pkg::EDGE_TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        icl_pkg::REG_CELL_COUNT: cell_count     <= cfg_data[IW-1:0];
        icl_pkg::REG_EDGE_TOL:   edge_tolerance <= cfg_data[icl_pkg::TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // count limited to the table depth
  assign eff_count = (32'(cell_count) > CELL_DEPTH) ? IW'(CELL_DEPTH) : cell_count;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign pos_past_end = pos >= eff_count;

  // cell table: lower edge in the upper half, upper edge in the lower half
  icl_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (CELL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_ch.load_index)),
    .wdata ({in_ch.lower_edge, in_ch.upper_edge}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_lower = mem_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign rd_upper = mem_rdata[COORD_WIDTH-1:0];

  icl_edge_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_cmp_lower (
    .value     (x_val),
    .edge_pos  (rd_lower),
    .tolerance (edge_tolerance),
    .result    (cmp_lower)
  );

  icl_edge_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_cmp_upper (
    .value     (x_val),
    .edge_pos  (rd_upper),
    .tolerance (edge_tolerance),
    .result    (cmp_upper)
  );

  // decision on the cell just read
  always_comb begin
    eval_finish  = 1'b0;
    eval_found   = 1'b0;
    eval_restart = 1'b0;
    if (hint_phase && cmp_lower.near) begin
      if (bias) begin
        eval_finish = 1'b1;
        eval_found  = 1'b1;
      end else begin
        eval_restart = 1'b1;
      end
    end else if (hint_phase && cmp_lower.below) begin
      eval_restart = 1'b1;
    end else if (cmp_lower.near) begin
      eval_finish = 1'b1;
      eval_found  = bias;
    end else if (cmp_upper.near) begin
      if (!bias) begin
        eval_finish = 1'b1;
        eval_found  = 1'b1;
      end
    end else if (cmp_lower.below) begin
      eval_finish = 1'b1;
    end else if (cmp_upper.below) begin
      eval_finish = 1'b1;
      eval_found  = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      icl_pkg::ST_IDLE: begin
        if (in_xfer && in_ch.kind == icl_pkg::KIND_QUERY) begin
          state_next = icl_pkg::ST_LOOK;
        end
      end
      icl_pkg::ST_LOOK: begin
        state_next = pos_past_end ? icl_pkg::ST_DONE : icl_pkg::ST_EVAL;
      end
      icl_pkg::ST_EVAL: begin
        state_next = eval_finish ? icl_pkg::ST_DONE : icl_pkg::ST_LOOK;
      end
      icl_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = icl_pkg::ST_IDLE;
        end
      end
      default: state_next = icl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = AW'(pos);
    out_load    = 1'b0;
    case (state)
      icl_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_we      = in_ch.valid && in_ch.kind == icl_pkg::KIND_LOAD &&
                      32'(in_ch.load_index) < CELL_DEPTH;
      end
      icl_pkg::ST_LOOK: mem_raddr = AW'(pos);
      icl_pkg::ST_EVAL: ;
      icl_pkg::ST_DONE: out_load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  // search position and result
  always_comb begin
    pos_next        = pos;
    hint_phase_next = hint_phase;
    res_index_next  = res_index;
    res_found_next  = res_found;
    case (state)
      icl_pkg::ST_IDLE: begin
        hint_phase_next = in_ch.start_hint < eff_count;
        pos_next        = hint_phase_next ? in_ch.start_hint : '0;
      end
      icl_pkg::ST_LOOK: begin
        if (pos_past_end) begin
          res_index_next = pos;
          res_found_next = 1'b0;
        end
      end
      icl_pkg::ST_EVAL: begin
        hint_phase_next = 1'b0;
        if (eval_finish) begin
          res_index_next = pos;
          res_found_next = eval_found;
        end else if (eval_restart) begin
          pos_next = '0;
        end else begin
          pos_next = pos + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= icl_pkg::ST_IDLE;
      hint_phase <= 1'b0;
    end else begin
      state      <= state_next;
      hint_phase <= hint_phase_next;
    end
  end

  // query payload and search registers
  always_ff @(posedge clk) begin
    pos       <= pos_next;
    res_index <= res_index_next;
    res_found <= res_found_next;
    if (in_xfer) begin
      x_val <= in_ch.value;
      bias  <= in_ch.bias_right;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= res_index;
      out_found <= res_found;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.cell_index = out_index;
  assign out_ch.found      = out_found;

endmodule
